// File: hw/rtl/pgemv_pkg.sv
package pgemv_pkg;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    typedef enum logic [1:0] {
        MODE_STORE = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_SUB   = 2'd2,
        MODE_SUB3  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [31:0] a_row0;
        logic [31:0] a_row1;
        logic [31:0] x_val;
        logic [31:0] y_prior0;
        logic [31:0] y_prior1;
        logic [1:0]  mode;
        logic        last;
    } t_item;

    typedef struct packed {
        logic [31:0] y_out0;
        logic [31:0] y_out1;
    } t_result;

    // unpacked float: value = (-1)^s * m * 2^(e-150), m 24 bits with hidden bit
    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        zero;
        logic        s;
        logic [9:0]  e;
        logic [23:0] m;
    } t_unp;

    function automatic t_unp fp_unpack(input logic [31:0] f);
        t_unp u;
        u.s    = f[31];
        u.nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
        u.inf  = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
        u.zero = (f[30:0] == 31'd0);
        if (f[30:23] == 8'd0) begin
            u.e = 10'd1;
            u.m = {1'b0, f[22:0]};
        end else begin
            u.e = {2'b00, f[30:23]};
            u.m = {1'b1, f[22:0]};
        end
        return u;
    endfunction

    // round to nearest-even; exp is the biased exponent of the hidden bit sig[26],
    // already clamped to 1 for subnormal results
    function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] exp,
                                             input logic [26:0] sig);
        // sig: [26] hidden bit, [25:3] mantissa, [2] guard, [1] round, [0] sticky
        logic [24:0] r;
        logic        inc;
        logic [31:0] o;
        inc = sig[2] & (sig[1] | sig[0] | sig[3]);
        r   = {1'b0, sig[26:3]} + {24'd0, inc};
        o   = 32'd0;
        if (r[24]) begin
            if (exp + 12'sd1 >= 12'sd255) o = {s, 8'hFF, 23'd0};
            else o = {s, 8'(exp + 12'sd1), r[23:1]};
        end else if (exp >= 12'sd255) begin
            o = {s, 8'hFF, 23'd0};
        end else if (r[23]) begin
            o = {s, 8'(exp), r[22:0]};
        end else begin
            o = {s, 8'd0, r[22:0]};
        end
        return o;
    endfunction

endpackage

// File: hw/rtl/pgemv_if.sv
interface pgemv_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/pgemv_fmul.sv
// Single-precision multiply, two stages: mantissa product, then normalize and round.
module pgemv_fmul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);
    pgemv_pkg::t_unp ua, ub;
    logic [47:0]        r_prod;
    logic               r_s, r_nan, r_inf, r_zero;
    logic signed [11:0] r_exp;
    logic               n_nan;

    always_comb begin
        ua = pgemv_pkg::fp_unpack(i_a);
        ub = pgemv_pkg::fp_unpack(i_b);
        n_nan = ua.nan | ub.nan | (ua.inf & ub.zero) | (ub.inf & ua.zero);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= ua.m * ub.m;
            r_s    <= ua.s ^ ub.s;
            r_nan  <= n_nan;
            r_inf  <= ua.inf | ub.inf;
            r_zero <= ua.zero | ub.zero;
            // exponent of product bit 46 (weight as biased exponent)
            r_exp  <= $signed({2'b00, ua.e}) + $signed({2'b00, ub.e}) - 12'sd127;
        end
    end

    // normalize: find leading one, shift to bit 47, adjust exponent
    logic [5:0]         lz;
    logic [47:0]        nrm;
    logic signed [11:0] e1;
    logic [26:0]        sig;
    logic [47:0]        sh;
    logic [5:0]         dsh;
    logic [47:0]        sticky_mask;
    always_comb begin
        lz = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (r_prod[i]) lz = 6'(47 - i);
        end
        nrm = r_prod << lz;
        e1  = r_exp + 12'sd1 - $signed({6'd0, lz});
        // subnormal: shift right so exponent becomes 1
        dsh = 6'd0;
        if (e1 < 12'sd1) begin
            dsh = (e1 < -12'sd40) ? 6'd48 : 6'(12'sd1 - e1);
            e1  = 12'sd1;
        end
        sh = nrm >> dsh;
        sticky_mask = ~(48'hFFFF_FFFF_FFFF << dsh);
        sig = {sh[47:22], (|sh[21:0]) | (|(nrm & sticky_mask))};
        if (r_nan) o_p = pgemv_pkg::QNAN;
        else if (r_inf) o_p = {r_s, 8'hFF, 23'd0};
        else if (r_zero) o_p = {r_s, 31'd0};
        else o_p = pgemv_pkg::fp_round(r_s, e1, sig);
    end
endmodule

// File: hw/rtl/pgemv_fadd.sv
// Single-precision add, two stages: align and add, then normalize and round.
module pgemv_fadd (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_s
);
    pgemv_pkg::t_unp ua, ub, ux, uy;
    logic [9:0]         d;
    logic [50:0]        mx, my;
    logic               sub;
    logic [50:0]        n_sum;
    logic signed [11:0] n_e;
    logic               n_spec;
    logic [31:0]        n_spec_v;

    logic [50:0]        r_sum;
    logic signed [11:0] r_e;
    logic               r_rs, r_zs, r_spec;
    logic [31:0]        r_spec_v;

    logic [5:0]         lz;
    logic [50:0]        nrm;
    logic signed [11:0] e1;
    logic [5:0]         dsh;
    logic [50:0]        sh;
    logic [26:0]        sig;

    always_comb begin
        ua = pgemv_pkg::fp_unpack(i_a);
        ub = pgemv_pkg::fp_unpack(i_b);
        if ({ub.e, ub.m} > {ua.e, ua.m}) begin
            ux = ub; uy = ua;
        end else begin
            ux = ua; uy = ub;
        end
        d   = ux.e - uy.e;
        mx  = {1'b0, ux.m, 26'd0};
        my  = {1'b0, uy.m, 26'd0};
        if (d > 10'd50) my = {50'd0, |uy.m};
        else my = (my >> d) | {50'd0, |(my & ~(51'h7_FFFF_FFFF_FFFF << d))};
        sub   = ux.s ^ uy.s;
        n_sum = sub ? mx - my : mx + my;
        // bit 50 weight exponent ux.e + 1
        n_e   = $signed({2'b00, ux.e}) + 12'sd1;
        n_spec   = 1'b1;
        n_spec_v = pgemv_pkg::QNAN;
        if (ua.nan | ub.nan | (ua.inf & ub.inf & (ua.s ^ ub.s))) n_spec_v = pgemv_pkg::QNAN;
        else if (ua.inf) n_spec_v = i_a;
        else if (ub.inf) n_spec_v = i_b;
        else begin
            n_spec   = 1'b0;
            n_spec_v = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_e      <= n_e;
        r_rs     <= ux.s;
        r_zs     <= ua.s & ub.s;
        r_spec   <= n_spec;
        r_spec_v <= n_spec_v;
    end

    always_comb begin
        lz = 6'd0;
        for (int i = 0; i < 51; i++) begin
            if (r_sum[i]) lz = 6'(50 - i);
        end
        nrm = r_sum << lz;
        e1  = r_e - $signed({6'd0, lz});
        dsh = 6'd0;
        if (e1 < 12'sd1) begin
            dsh = 6'(12'sd1 - e1);
            e1  = 12'sd1;
        end
        sh  = nrm >> dsh;
        sig = {sh[50:25], |sh[24:0]};
        if (r_spec) o_s = r_spec_v;
        else if (r_sum == 51'd0) o_s = {r_zs, 31'd0};
        else o_s = pgemv_pkg::fp_round(r_rs, e1, sig);
    end
endmodule

// File: hw/rtl/pgemv_front.sv
// Accepts items and forms both products; feeds a two-entry queue.
module pgemv_front (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pgemv_if.sink    s_in,
    output logic     o_valid,
    input  logic     i_ready,
    output logic [31:0] o_p0,
    output logic [31:0] o_p1,
    output pgemv_pkg::t_item o_item
);
    // one item in the multiplier at a time: stage valid
    logic r_v;
    pgemv_pkg::t_item r_item;
    logic [31:0] p0, p1;
    logic [31:0] r_q_p0 [2];
    logic [31:0] r_q_p1 [2];
    pgemv_pkg::t_item r_q_item [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic take, push, pop;

    assign push = r_v && (r_cnt != 2'd2);
    assign pop  = (r_cnt != 2'd0) && i_ready;
    assign s_in.ready = !r_v || push;
    assign take = s_in.valid && s_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (take) r_v <= 1'b1;
            else if (push) r_v <= 1'b0;
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            case ({push, pop})
                2'b10: r_cnt <= r_cnt + 2'd1;
                2'b01: r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (take) r_item <= s_in.data;
        if (push) begin
            r_q_p0[r_wp]   <= p0;
            r_q_p1[r_wp]   <= p1;
            r_q_item[r_wp] <= r_item;
        end
    end
    pgemv_fmul u_m0 (.i_clk, .i_en(take), .i_a(s_in.data.a_row0), .i_b(s_in.data.x_val),
                     .o_p(p0));
    pgemv_fmul u_m1 (.i_clk, .i_en(take), .i_a(s_in.data.a_row1), .i_b(s_in.data.x_val),
                     .o_p(p1));
    assign o_valid = (r_cnt != 2'd0);
    assign o_p0    = r_q_p0[r_rp];
    assign o_p1    = r_q_p1[r_rp];
    assign o_item  = r_q_item[r_rp];
endmodule

// File: hw/rtl/pgemv_back.sv
// Accumulates products and does the final combine; the adders register their sums.
module pgemv_back #(parameter int ROWS = 2) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_p0,
    input  logic [31:0] i_p1,
    input  pgemv_pkg::t_item i_item,
    pgemv_if.source     m_out
);
    typedef enum logic [2:0] {S_ACC, S_ACC_W, S_COMB, S_COMB_W, S_OUT} t_state;
    t_state      r_state;
    logic [31:0] r_acc0, r_acc1;
    logic [31:0] r_pr0, r_pr1;
    logic [1:0]  r_mode;
    logic        r_last;
    logic [31:0] a0, a1, b0, b1, s0, s1;

    assign o_ready = (r_state == S_ACC);

    always_comb begin
        if (r_state == S_ACC) begin
            a0 = r_acc0; b0 = i_p0; a1 = r_acc1; b1 = i_p1;
        end else begin
            a0 = r_pr0; a1 = r_pr1;
            b0 = (r_mode == pgemv_pkg::MODE_ADD) ? r_acc0 : {~r_acc0[31], r_acc0[30:0]};
            b1 = (r_mode == pgemv_pkg::MODE_ADD) ? r_acc1 : {~r_acc1[31], r_acc1[30:0]};
        end
    end
    pgemv_fadd u_a0 (.i_clk, .i_a(a0), .i_b(b0), .o_s(s0));
    pgemv_fadd u_a1 (.i_clk, .i_a(a1), .i_b(b1), .o_s(s1));

    function automatic logic [31:0] canon(input logic [31:0] f);
        return (f[30:23] == 8'hFF && f[22:0] != 23'd0) ? pgemv_pkg::QNAN : f;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_acc0  <= 32'd0;
            r_acc1  <= 32'd0;
            m_out.valid <= 1'b0;
        end else begin
            case (r_state)
                S_ACC: if (i_valid) begin
                    r_pr0   <= i_item.y_prior0;
                    r_pr1   <= i_item.y_prior1;
                    r_mode  <= i_item.mode;
                    r_last  <= i_item.last;
                    r_state <= S_ACC_W;
                end
                S_ACC_W: begin
                    r_acc0  <= s0;
                    r_acc1  <= (ROWS >= 2) ? s1 : 32'd0;
                    r_state <= r_last ? S_COMB : S_ACC;
                end
                // adders take prior and the signed sums this cycle
                S_COMB: r_state <= S_COMB_W;
                S_COMB_W: begin
                    m_out.data.y_out0 <= canon((r_mode == pgemv_pkg::MODE_STORE) ? r_acc0 : s0);
                    m_out.data.y_out1 <= (ROWS >= 2) ?
                        canon((r_mode == pgemv_pkg::MODE_STORE) ? r_acc1 : s1) : 32'd0;
                    m_out.valid <= 1'b1;
                    r_acc0  <= 32'd0;
                    r_acc1  <= 32'd0;
                    r_state <= S_OUT;
                end
                S_OUT: if (m_out.ready) begin
                    m_out.valid <= 1'b0;
                    r_state <= S_ACC;
                end
                default: r_state <= S_ACC;
            endcase
        end
    end
endmodule

// File: hw/rtl/panel_gemv_two_row_mac_core.sv
// Two-row single-precision GEMV column engine. Each request brings one column
// (two matrix elements, one vector element); products are rounded, then added
// in arrival order to per-row accumulators, with no fused multiply-add. A last
// request emits y = sum, prior + sum, or prior - sum and clears the sums. The
// front multiplies each column and passes products through a two-entry queue;
// the back takes no new request until the two-stage adder in the accumulate
// loop has written its sums back. A last request then passes S_ACC_W, S_COMB
// and S_COMB_W before its registered result is offered in S_OUT, and the back
// takes the next request in the cycle after the output handshake.
// NaN results are emitted as 0x7FC00000. ROWS=1 gives a one-row engine with
// y_out1 held at zero.
module panel_gemv_two_row_mac_core #(parameter int ROWS = 2) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pgemv_if.sink   s_in,
    pgemv_if.source m_out
);
    logic        fv, br;
    logic [31:0] p0, p1;
    pgemv_pkg::t_item it;

    pgemv_front u_front (.i_clk, .i_rst_n, .s_in, .o_valid(fv), .i_ready(br),
                         .o_p0(p0), .o_p1(p1), .o_item(it));
    pgemv_back #(.ROWS(ROWS)) u_back (.i_clk, .i_rst_n, .i_valid(fv), .o_ready(br),
                                      .i_p0(p0), .i_p1(p1), .i_item(it), .m_out);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data))
        else $error("result dropped");
    a_nan0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && m_out.data.y_out0[30:23] == 8'hFF |->
        m_out.data.y_out0[22:0] == 23'd0 || m_out.data.y_out0 == pgemv_pkg::QNAN)
        else $error("non-canonical NaN");
endmodule
